// File: rtl/acsm_pkg.sv
// Shared types and codes for the alarm clock set menu.
// Used by acsm_core and alarm_clock_set_menu_top; no dependencies.
package acsm_pkg;

    // Event codes on the input channel.
    localparam logic [2:0] FUNC_UP     = 3'd0;
    localparam logic [2:0] FUNC_DOWN   = 3'd1;
    localparam logic [2:0] FUNC_SET    = 3'd2;
    localparam logic [2:0] FUNC_SNOOZE = 3'd3;
    localparam logic [2:0] FUNC_MONO   = 3'd4;

    // Seek request codes.
    localparam logic [1:0] SEEK_NONE = 2'd0;
    localparam logic [1:0] SEEK_UP   = 2'd1;
    localparam logic [1:0] SEEK_DOWN = 2'd2;

    // Commit codes.
    localparam logic [1:0] COMMIT_NONE  = 2'd0;
    localparam logic [1:0] COMMIT_ALARM = 2'd1;
    localparam logic [1:0] COMMIT_CLOCK = 2'd2;
    localparam logic [1:0] COMMIT_MONO  = 2'd3;

    // Alarm event codes.
    localparam logic [1:0] AEV_NONE   = 2'd0;
    localparam logic [1:0] AEV_SNOOZE = 2'd1;
    localparam logic [1:0] AEV_OFF    = 2'd2;

    // Mute command codes.
    localparam logic [1:0] MUTE_KEEP = 2'd0;
    localparam logic [1:0] MUTE_ON   = 2'd1;
    localparam logic [1:0] MUTE_OFF  = 2'd2;

    // Configuration register indexes and reset values.
    localparam logic       REG_SNOOZE_STEP   = 1'b0;
    localparam logic       REG_LONG_PRESS_MS = 1'b1;
    localparam logic [5:0] SNOOZE_STEP_RST   = 6'd5;
    localparam logic [15:0] LONG_PRESS_MS_RST = 16'd3000;

    // Configuration seen by the menu logic.
    typedef struct packed {
        logic [5:0]  snooze_step;
        logic [15:0] long_press_ms;
    } cfg_t;

    // One input item.
    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] held_ms;
        logic [4:0]  now_hour;
        logic [5:0]  now_minute;
        logic        alarm_ringing;
    } item_t;

    // One result item.
    typedef struct packed {
        logic [2:0] menu_mode;
        logic [5:0] edit_value;
        logic [4:0] alarm_hour_out;
        logic [5:0] alarm_minute_out;
        logic       alarm_armed;
        logic [1:0] seek_request;
        logic [1:0] commit;
        logic [4:0] clock_set_hour;
        logic [5:0] clock_set_minute;
        logic [1:0] alarm_event;
        logic [1:0] mute_command;
        logic       mono_forced;
    } result_t;

endpackage

// File: rtl/acsm_core.sv
// Menu state and per-item update logic of the alarm clock set menu.
// Depends on acsm_pkg for the item, result and configuration types.
module acsm_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  acsm_pkg::item_t   item,
    input  acsm_pkg::cfg_t    cfg,
    output acsm_pkg::result_t res
);
    import acsm_pkg::*;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_AHOUR  = 3'd1,
        MODE_AMIN   = 3'd2,
        MODE_CHOUR  = 3'd3,
        MODE_CMIN   = 3'd4
    } mode_t;

    localparam logic [5:0] HOURS     = 6'd24;
    localparam logic [6:0] MINUTES   = 7'd60;
    localparam logic [6:0] MINUTES_2 = 7'd120;
    localparam logic [4:0] HOUR_TOP  = 5'd23;
    localparam logic [5:0] MIN_TOP   = 6'd59;

    // Hour plus one modulo 24; inputs up to 31 stay below twice the modulus.
    function automatic logic [4:0] inc_hour(input logic [4:0] v);
        logic [5:0] s;
        s = {1'b0, v} + 6'd1;
        if (s >= HOURS) begin
            s = s - HOURS;
        end
        return s[4:0];
    endfunction

    function automatic logic [5:0] inc_minute(input logic [5:0] v);
        logic [6:0] s;
        s = {1'b0, v} + 7'd1;
        if (s >= MINUTES) begin
            s = s - MINUTES;
        end
        return s[5:0];
    endfunction

    function automatic logic [4:0] dec_hour(input logic [4:0] v);
        return (v == 5'd0) ? HOUR_TOP : v - 5'd1;
    endfunction

    function automatic logic [5:0] dec_minute(input logic [5:0] v);
        return (v == 6'd0) ? MIN_TOP : v - 6'd1;
    endfunction

    mode_t      mode_reg, mode_next;
    logic [4:0] edit_alarm_hour_reg, edit_alarm_hour_next;
    logic [5:0] edit_alarm_minute_reg, edit_alarm_minute_next;
    logic [4:0] edit_clock_hour_reg, edit_clock_hour_next;
    logic [5:0] edit_clock_minute_reg, edit_clock_minute_next;
    logic [4:0] alarm_hour_reg, alarm_hour_next;
    logic [5:0] alarm_minute_reg, alarm_minute_next;
    logic       alarm_enabled_reg, alarm_enabled_next;
    logic       snoozed_reg, snoozed_next;
    logic       radio_muted_reg, radio_muted_next;
    logic       force_mono_reg, force_mono_next;

    logic       up;
    logic [6:0] snooze_sum;

    assign up         = (item.func == FUNC_UP);
    assign snooze_sum = {1'b0, alarm_minute_reg} + {1'b0, cfg.snooze_step};

    // Next state and per-item outputs for the current item.
    always_comb begin
        mode_next              = mode_reg;
        edit_alarm_hour_next   = edit_alarm_hour_reg;
        edit_alarm_minute_next = edit_alarm_minute_reg;
        edit_clock_hour_next   = edit_clock_hour_reg;
        edit_clock_minute_next = edit_clock_minute_reg;
        alarm_hour_next        = alarm_hour_reg;
        alarm_minute_next      = alarm_minute_reg;
        alarm_enabled_next     = alarm_enabled_reg;
        snoozed_next           = snoozed_reg;
        radio_muted_next       = radio_muted_reg;
        force_mono_next        = force_mono_reg;
        res                    = '0;

        case (item.func) inside
            FUNC_UP, FUNC_DOWN: begin
                unique case (mode_reg)
                    MODE_NORMAL: begin
                        res.seek_request = up ? SEEK_UP : SEEK_DOWN;
                    end
                    MODE_AHOUR: begin
                        edit_alarm_hour_next = up ? inc_hour(edit_alarm_hour_reg)
                                                  : dec_hour(edit_alarm_hour_reg);
                    end
                    MODE_AMIN: begin
                        edit_alarm_minute_next = up ? inc_minute(edit_alarm_minute_reg)
                                                    : dec_minute(edit_alarm_minute_reg);
                    end
                    MODE_CHOUR: begin
                        edit_clock_hour_next = up ? inc_hour(edit_clock_hour_reg)
                                                  : dec_hour(edit_clock_hour_reg);
                    end
                    default: begin
                        edit_clock_minute_next = up ? inc_minute(edit_clock_minute_reg)
                                                    : dec_minute(edit_clock_minute_reg);
                    end
                endcase
            end
            FUNC_SET: begin
                if (item.held_ms >= cfg.long_press_ms) begin
                    // A long press only acts from normal mode.
                    if (mode_reg == MODE_NORMAL) begin
                        mode_next              = MODE_CHOUR;
                        edit_clock_hour_next   = item.now_hour;
                        edit_clock_minute_next = item.now_minute;
                    end
                end else begin
                    unique case (mode_reg)
                        MODE_NORMAL: begin
                            mode_next              = MODE_AHOUR;
                            edit_alarm_hour_next   = alarm_hour_reg;
                            edit_alarm_minute_next = alarm_minute_reg;
                        end
                        MODE_AHOUR: mode_next = MODE_AMIN;
                        MODE_AMIN: begin
                            alarm_hour_next    = edit_alarm_hour_reg;
                            alarm_minute_next  = edit_alarm_minute_reg;
                            alarm_enabled_next = 1'b1;
                            res.commit         = COMMIT_ALARM;
                            mode_next          = MODE_NORMAL;
                        end
                        MODE_CHOUR: mode_next = MODE_CMIN;
                        default: begin
                            res.commit           = COMMIT_CLOCK;
                            res.clock_set_hour   = edit_clock_hour_reg;
                            res.clock_set_minute = edit_clock_minute_reg;
                            mode_next            = MODE_NORMAL;
                        end
                    endcase
                end
            end
            FUNC_SNOOZE: begin
                if (item.alarm_ringing) begin
                    res.mute_command = MUTE_ON;
                    if (!snoozed_reg) begin
                        // First snooze pushes the alarm out, carrying into the hour.
                        snoozed_next    = 1'b1;
                        res.alarm_event = AEV_SNOOZE;
                        if (snooze_sum >= MINUTES) begin
                            alarm_hour_next = inc_hour(alarm_hour_reg);
                        end
                        if (snooze_sum >= MINUTES_2) begin
                            alarm_minute_next = 6'(snooze_sum - MINUTES_2);
                        end else if (snooze_sum >= MINUTES) begin
                            alarm_minute_next = 6'(snooze_sum - MINUTES);
                        end else begin
                            alarm_minute_next = snooze_sum[5:0];
                        end
                    end else begin
                        // Second snooze switches off and restores the set alarm time.
                        snoozed_next      = 1'b0;
                        alarm_hour_next   = edit_alarm_hour_reg;
                        alarm_minute_next = edit_alarm_minute_reg;
                        res.alarm_event   = AEV_OFF;
                    end
                end else begin
                    radio_muted_next = ~radio_muted_reg;
                    res.mute_command = radio_muted_next ? MUTE_ON : MUTE_OFF;
                end
            end
            FUNC_MONO: begin
                if (mode_reg == MODE_NORMAL) begin
                    force_mono_next = ~force_mono_reg;
                    res.commit      = COMMIT_MONO;
                end
            end
            default: begin
                // Unused event codes leave everything unchanged.
            end
        endcase

        // State fields of the result reflect the state after this item.
        res.menu_mode        = mode_next;
        res.alarm_hour_out   = alarm_hour_next;
        res.alarm_minute_out = alarm_minute_next;
        res.alarm_armed      = alarm_enabled_next;
        res.mono_forced      = force_mono_next;
        unique case (mode_next)
            MODE_AHOUR:  res.edit_value = {1'b0, edit_alarm_hour_next};
            MODE_AMIN:   res.edit_value = edit_alarm_minute_next;
            MODE_CHOUR:  res.edit_value = {1'b0, edit_clock_hour_next};
            MODE_CMIN:   res.edit_value = edit_clock_minute_next;
            default:     res.edit_value = 6'd0;
        endcase
    end

    // Menu state registers, updated once per accepted item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg              <= MODE_NORMAL;
            edit_alarm_hour_reg   <= '0;
            edit_alarm_minute_reg <= '0;
            edit_clock_hour_reg   <= '0;
            edit_clock_minute_reg <= '0;
            alarm_hour_reg        <= '0;
            alarm_minute_reg      <= '0;
            alarm_enabled_reg     <= 1'b0;
            snoozed_reg           <= 1'b0;
            radio_muted_reg       <= 1'b0;
            force_mono_reg        <= 1'b0;
        end else if (fire) begin
            mode_reg              <= mode_next;
            edit_alarm_hour_reg   <= edit_alarm_hour_next;
            edit_alarm_minute_reg <= edit_alarm_minute_next;
            edit_clock_hour_reg   <= edit_clock_hour_next;
            edit_clock_minute_reg <= edit_clock_minute_next;
            alarm_hour_reg        <= alarm_hour_next;
            alarm_minute_reg      <= alarm_minute_next;
            alarm_enabled_reg     <= alarm_enabled_next;
            snoozed_reg           <= snoozed_next;
            radio_muted_reg       <= radio_muted_next;
            force_mono_reg        <= force_mono_next;
        end
    end

    // A seek is requested only from normal mode.
    a_seek_normal: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res.seek_request != SEEK_NONE |-> mode_reg == MODE_NORMAL)
        else $error("seek requested outside normal mode");

    // Mono toggle outside normal mode leaves the preference alone.
    a_mono_ignored: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.func == FUNC_MONO && mode_reg != MODE_NORMAL |=> $stable(force_mono_reg))
        else $error("mono preference changed outside normal mode");

    // Committing the alarm arms it.
    a_alarm_armed: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res.commit == COMMIT_ALARM |=> alarm_enabled_reg)
        else $error("alarm commit did not arm the alarm");

endmodule

// File: rtl/alarm_clock_set_menu_top.sv
// Top level of the alarm clock set menu: APB registers, input and result registers.
// Depends on acsm_pkg and acsm_core.
//
// Usage: button events enter on the s_ channel (valid/ready), one item per
// event, and each produces exactly one result item on the m_ channel. An item
// is first captured in an input register; when the result register is free,
// the menu logic in acsm_core updates its state and the result is captured
// in the result register, which drives m_valid. One item is taken per cycle
// while the receiver does not stall.
// When the receiver stalls, the result register holds its item and the input
// register can still take one more; s_ready then drops until m_ready returns.
// The APB port holds the snooze step at address 0 and long_press_ms at address
// 4; pready is always high and writes complete in the access cycle. Write
// them only while no item is in flight.
// Reset (aresetn low, synchronous) empties both registers, returns the menu
// to normal mode with the alarm at 00:00 and disarmed, unmuted and stereo,
// and loads the register reset values.
module alarm_clock_set_menu_top (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_func,
    input  logic [15:0] s_held_ms,
    input  logic [4:0]  s_now_hour,
    input  logic [5:0]  s_now_minute,
    input  logic        s_alarm_ringing,
    // Result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_menu_mode,
    output logic [5:0]  m_edit_value,
    output logic [4:0]  m_alarm_hour_out,
    output logic [5:0]  m_alarm_minute_out,
    output logic        m_alarm_armed,
    output logic [1:0]  m_seek_request,
    output logic [1:0]  m_commit,
    output logic [4:0]  m_clock_set_hour,
    output logic [5:0]  m_clock_set_minute,
    output logic [1:0]  m_alarm_event,
    output logic [1:0]  m_mute_command,
    output logic        m_mono_forced
);
    import acsm_pkg::*;

    cfg_t    cfg_reg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t out_reg;
    logic    out_valid_reg;
    result_t core_res;
    logic    out_free;
    logic    fire;
    logic    cfg_write;

    // Configuration writes and reads.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.snooze_step   <= SNOOZE_STEP_RST;
            cfg_reg.long_press_ms <= LONG_PRESS_MS_RST;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_SNOOZE_STEP: cfg_reg.snooze_step   <= pwdata[5:0];
                default:         cfg_reg.long_press_ms <= pwdata[15:0];
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_SNOOZE_STEP: prdata = {26'd0, cfg_reg.snooze_step};
            default:         prdata = {16'd0, cfg_reg.long_press_ms};
        endcase
    end

    // Pipeline control: the input item moves on when the result slot is free.
    assign out_free = !out_valid_reg || m_ready;
    assign fire     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.func          <= s_func;
            in_item_reg.held_ms       <= s_held_ms;
            in_item_reg.now_hour      <= s_now_hour;
            in_item_reg.now_minute    <= s_now_minute;
            in_item_reg.alarm_ringing <= s_alarm_ringing;
        end
    end

    // Menu logic and state.
    acsm_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .res     (core_res)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg <= core_res;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_menu_mode        = out_reg.menu_mode;
    assign m_edit_value       = out_reg.edit_value;
    assign m_alarm_hour_out   = out_reg.alarm_hour_out;
    assign m_alarm_minute_out = out_reg.alarm_minute_out;
    assign m_alarm_armed      = out_reg.alarm_armed;
    assign m_seek_request     = out_reg.seek_request;
    assign m_commit           = out_reg.commit;
    assign m_clock_set_hour   = out_reg.clock_set_hour;
    assign m_clock_set_minute = out_reg.clock_set_minute;
    assign m_alarm_event      = out_reg.alarm_event;
    assign m_mute_command     = out_reg.mute_command;
    assign m_mono_forced      = out_reg.mono_forced;

    // The input side only stalls while it holds an item behind a stalled result.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && out_valid_reg && !m_ready)
        else $error("input stalled without a stalled result");

    // Clock time fields carry data only with a clock commit.
    a_clock_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_commit != COMMIT_CLOCK |-> m_clock_set_hour == 5'd0
            && m_clock_set_minute == 6'd0)
        else $error("clock time shown without a clock commit");

    // Snooze and alarm-off both mute the radio.
    a_event_mute: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_alarm_event != AEV_NONE |-> m_mute_command == MUTE_ON)
        else $error("alarm event without a mute command");

endmodule
